/* hdl/sfa_pkg.sv */
// Shared types, constants and helper functions for the segregated free-list allocator.
// No dependencies; every module imports this package.
package sfa_pkg;

    localparam int NUM_CLASSES          = 8;
    localparam int FREE_STACK_DEPTH_DEF = 2048;
    localparam int OFFSET_BITS_DEF      = 19;

    localparam int CLS_W        = 3;
    localparam int GSIZE_W      = 33;
    localparam int OFFSET_MAX_W = 32;
    localparam int FRESH_W      = 11;
    localparam int FOFF_W       = 24;
    localparam int STATUS_W     = 3;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 64;

    localparam logic [GSIZE_W-1:0] LARGE_LIMIT = 33'd4096;
    localparam logic [GSIZE_W-1:0] HDR_BYTES   = 33'd8;
    localparam logic [3:0]         MIN_SHIFT   = 4'd5;

    // Register index decoded from paddr[3]
    localparam logic REG_POOL_BASE = 1'b0;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK          = 3'd0,
        ST_LARGE_ALLOC = 3'd1,
        ST_EXHAUSTED   = 3'd2,
        ST_LARGE_FREE  = 3'd3,
        ST_STACK_FULL  = 3'd4
    } status_t;

    typedef enum logic
    {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

    // Classified request passed from front to back
    typedef struct packed
    {
        op_t                     op;
        logic                    oversize;
        logic [CLS_W-1:0]        cls;
        logic [GSIZE_W-1:0]      gsize;
        logic [OFFSET_MAX_W-1:0] offset;
    } cmd_t;

    function automatic logic [GSIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        class_bytes = 33'd32 << c;
    endfunction

    function automatic logic [FOFF_W-1:0] class_base(input logic [CLS_W-1:0] c);
        logic [FOFF_W-1:0] b;
        unique case (c)
            3'd0:    b = 24'd0;
            3'd1:    b = 24'd40960;
            3'd2:    b = 24'd81920;
            3'd3:    b = 24'd122880;
            3'd4:    b = 24'd163840;
            3'd5:    b = 24'd204800;
            3'd6:    b = 24'd245760;
            default: b = 24'd327680;
        endcase
        class_base = b;
    endfunction

    function automatic logic [FRESH_W-1:0] class_fresh(input logic [CLS_W-1:0] c);
        logic [FRESH_W-1:0] n;
        unique case (c)
            3'd0:    n = 11'd1280;
            3'd1:    n = 11'd640;
            3'd2:    n = 11'd320;
            3'd3:    n = 11'd160;
            3'd4:    n = 11'd80;
            3'd5:    n = 11'd40;
            3'd6:    n = 11'd40;
            default: n = 11'd20;
        endcase
        class_fresh = n;
    endfunction

endpackage

/* hdl/sfa_if.sv */
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on nothing; payload widths follow the request and response formats.
interface sfa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] request_bytes;
    logic [63:0] user_address;
    logic [32:0] block_size;

    modport source (output valid, output opcode, output request_bytes,
                    output user_address, output block_size, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input user_address, input block_size, output ready);
endinterface

interface sfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] granted_address;
    logic [32:0] granted_size;
    logic [2:0]  size_class;
    logic [2:0]  status;

    modport source (output valid, output granted_address, output granted_size,
                    output size_class, output status, input ready);
    modport sink   (input valid, input granted_address, input granted_size,
                    input size_class, input status, output ready);
endinterface

/* hdl/sfa_front.sv */
// Request front end: accepts a beat and classifies it into size class, size and slot offset.
// Depends on sfa_pkg and sfa_req_if.
module sfa_front
    import sfa_pkg::*;
(
    input  logic [OFFSET_MAX_W-1:0] pool_low,
    sfa_req_if.sink                 req,
    output cmd_t                    cmd,
    output logic                    cmd_valid,
    input  logic                    cmd_ready
);

    logic [GSIZE_W-1:0]      alloc_size;
    logic [CLS_W-1:0]        alloc_cls;
    logic [CLS_W-1:0]        free_cls;
    logic [OFFSET_MAX_W-1:0] free_off;
    logic                    alloc_large;
    logic                    free_large;

    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;

    always_comb
    begin
        alloc_size  = {1'b0, req.request_bytes} + HDR_BYTES;
        alloc_large = alloc_size > LARGE_LIMIT;
        free_large  = req.block_size > LARGE_LIMIT;

        // Smallest class that holds the size; small sizes land in class 0
        alloc_cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 2; i >= 0; i--)
        begin
            if (alloc_size <= class_bytes(CLS_W'(i)))
                alloc_cls = CLS_W'(i);
        end

        // Header size not naming a class goes to the largest class
        free_cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = 0; i < NUM_CLASSES - 1; i++)
        begin
            if (req.block_size == class_bytes(CLS_W'(i)))
                free_cls = CLS_W'(i);
        end

        // Only the low offset bits survive, so a narrow subtract suffices
        free_off = req.user_address[OFFSET_MAX_W-1:0] - OFFSET_MAX_W'(8) - pool_low;

        cmd.op = op_t'(req.opcode);
        if (req.opcode == OP_FREE)
        begin
            cmd.oversize = free_large;
            cmd.cls      = free_large ? '0 : free_cls;
            cmd.gsize    = '0;
            cmd.offset   = free_off;
        end
        else
        begin
            cmd.oversize = alloc_large;
            cmd.cls      = alloc_large ? '0 : alloc_cls;
            cmd.gsize    = alloc_large ? alloc_size : class_bytes(alloc_cls);
            cmd.offset   = '0;
        end
    end

endmodule

/* hdl/sfa_queue.sv */
// Two-entry queue of classified requests between front and back ends.
// Depends on sfa_pkg for the cmd_t entry type.
module sfa_queue
    import sfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_data
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

/* hdl/sfa_back.sv */
// Back end: per-class freed-slot stacks, fresh-slot counters and the response register.
// Depends on sfa_pkg and sfa_rsp_if.
module sfa_back
    import sfa_pkg::*;
#(
    parameter int FREE_STACK_DEPTH = FREE_STACK_DEPTH_DEF,
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] pool_base,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    sfa_rsp_if.source   rsp
);

    localparam int IDX_W     = $clog2(FREE_STACK_DEPTH);
    localparam int DEPTH_W   = $clog2(FREE_STACK_DEPTH + 1);
    localparam int MEM_W     = CLS_W + IDX_W;
    localparam int MEM_DEPTH = NUM_CLASSES << IDX_W;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(FREE_STACK_DEPTH);

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [DEPTH_W-1:0]       depth_reg  [NUM_CLASSES];
    logic [DEPTH_W-1:0]       depth_next [NUM_CLASSES];
    logic [FRESH_W-1:0]       fresh_reg  [NUM_CLASSES];
    logic [FRESH_W-1:0]       fresh_next [NUM_CLASSES];
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [63:0]              addr_reg;
    logic [63:0]              addr_next;
    logic [GSIZE_W-1:0]       gsize_reg;
    logic [GSIZE_W-1:0]       gsize_next;
    logic [CLS_W-1:0]         cls_reg;
    logic [CLS_W-1:0]         cls_next;
    status_t                  status_reg;
    status_t                  status_next;

    logic [OFFSET_BITS-1:0]   stack_mem [MEM_DEPTH];
    logic [OFFSET_BITS-1:0]   rd_data_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [MEM_W-1:0]         mem_addr;
    logic [OFFSET_BITS-1:0]   mem_wdata;

    logic [DEPTH_W-1:0]       dep;
    logic [DEPTH_W-1:0]       dep_dec;
    logic [FRESH_W-1:0]       fr;
    logic [FRESH_W-1:0]       fr_dec;
    logic [FOFF_W-1:0]        fresh_off;

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_address = addr_reg;
    assign rsp.granted_size    = gsize_reg;
    assign rsp.size_class      = cls_reg;
    assign rsp.status          = status_reg;

    always_comb
    begin
        dep        = depth_reg[cmd.cls];
        dep_dec    = dep - DEPTH_W'(1);
        fr         = fresh_reg[cmd.cls];
        fr_dec     = fr - FRESH_W'(1);
        // Fresh slots are handed out from the top of the class region down
        fresh_off  = class_base(cmd.cls)
                   + (FOFF_W'(fr_dec) << (MIN_SHIFT + {1'b0, cmd.cls}));

        state_next     = state_reg;
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        addr_next      = addr_reg;
        gsize_next     = gsize_reg;
        cls_next       = cls_reg;
        status_next    = status_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {cmd.cls, dep[IDX_W-1:0]};
        mem_wdata      = cmd.offset[OFFSET_BITS-1:0];

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || rsp.ready))
                begin
                    cmd_ready      = 1'b1;
                    out_valid_next = 1'b1;
                    addr_next      = '0;
                    gsize_next     = cmd.gsize;
                    cls_next       = cmd.cls;
                    status_next    = ST_OK;
                    if (cmd.op == OP_FREE)
                    begin
                        if (cmd.oversize)
                            status_next = ST_LARGE_FREE;
                        else if (dep == DEPTH_FULL)
                            status_next = ST_STACK_FULL;
                        else
                        begin
                            mem_we              = 1'b1;
                            depth_next[cmd.cls] = dep + DEPTH_W'(1);
                        end
                    end
                    else if (cmd.oversize)
                        status_next = ST_LARGE_ALLOC;
                    else if (dep != '0)
                    begin
                        // Pop the freed stack; address follows once read data lands
                        mem_re              = 1'b1;
                        mem_addr            = {cmd.cls, dep_dec[IDX_W-1:0]};
                        depth_next[cmd.cls] = dep_dec;
                        out_valid_next      = 1'b0;
                        state_next          = BK_READ;
                    end
                    else if (fr != '0)
                    begin
                        fresh_next[cmd.cls] = fr_dec;
                        addr_next           = pool_base + 64'(fresh_off) + 64'd8;
                    end
                    else
                        status_next = ST_EXHAUSTED;
                end
            end
            BK_READ:
            begin
                out_valid_next = 1'b1;
                addr_next      = pool_base + 64'(rd_data_reg) + 64'd8;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                depth_reg[i] <= '0;
                fresh_reg[i] <= class_fresh(CLS_W'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        gsize_reg  <= gsize_next;
        cls_reg    <= cls_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_addr];
    end

endmodule

/* hdl/segregated_freelist_allocator_core.sv */
// Segregated-fit allocator over a 409600-byte pool with eight power-of-two classes
// (32 to 4096 bytes). One request beat in, one response beat out. A request that
// pops a freed slot also passes through the BK_READ state, since the freed-slot stack
// memory has a registered read port. A two-entry queue between the classifying front
// end and the back end, plus the response register, keep requests flowing while a
// response waits. pool_base sits at byte address 0 of the APB port; write it while idle.
// Freed-slot stack contents are undefined after reset; no clearing pass is needed.
// Depends on sfa_pkg, sfa_if, sfa_front, sfa_queue and sfa_back.
module segregated_freelist_allocator_core
    import sfa_pkg::*;
#(
    parameter int FREE_STACK_DEPTH = FREE_STACK_DEPTH_DEF,
    parameter int OFFSET_BITS      = OFFSET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sfa_req_if.sink            req,
    sfa_rsp_if.source          rsp
);

    logic [63:0] pool_base_reg;
    logic        cfg_write;
    cmd_t        front_cmd;
    logic        front_valid;
    logic        front_ready;
    cmd_t        back_cmd;
    logic        back_valid;
    logic        back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[3] == REG_POOL_BASE);
    assign prdata    = (paddr[3] == REG_POOL_BASE) ? pool_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_base_reg <= '0;
        else if (cfg_write)
            pool_base_reg <= pwdata;
    end

    sfa_front u_front
    (
        .pool_low  (pool_base_reg[OFFSET_MAX_W-1:0]),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    sfa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_cmd)
    );

    sfa_back #(
        .FREE_STACK_DEPTH (FREE_STACK_DEPTH),
        .OFFSET_BITS      (OFFSET_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_base (pool_base_reg),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );

endmodule
